[rtl/bmdd_pkg.sv]
package bmdd_pkg;

  // Width of one display word and its fields.
  localparam int unsigned WORD_W  = 29;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned BARS_W  = 5;
  localparam int unsigned IND_W   = 3;
  localparam int unsigned MV_W    = 16;
  localparam int unsigned STAT_W  = 8;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned DIGIT_W = 4;

  // Charge window in millivolts.
  localparam logic [14:0] VoltLowMv  = 15'd3000;
  localparam logic [14:0] VoltHighMv = 15'd3800;
  // Highest voltage that still rounds below one thousand tens.
  localparam logic [14:0] VoltSatMv  = 15'd9994;

  // Mode indicator codes.
  localparam logic [IND_W-1:0] IndVolt = 3'b011;
  localparam logic [IND_W-1:0] IndPct  = 3'b100;

  // Level bar patterns.
  localparam logic [BARS_W-1:0] Bars5 = 5'b11111;
  localparam logic [BARS_W-1:0] Bars4 = 5'b11110;
  localparam logic [BARS_W-1:0] Bars3 = 5'b11100;
  localparam logic [BARS_W-1:0] Bars2 = 5'b11000;
  localparam logic [BARS_W-1:0] Bars1 = 5'b10000;
  localparam logic [BARS_W-1:0] Bars0 = 5'b00000;

  // Seven-segment pattern of one decimal digit; a code above nine is blank.
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'b0111111;
      4'd1:    s = 7'b0000011;
      4'd2:    s = 7'b1101101;
      4'd3:    s = 7'b1100111;
      4'd4:    s = 7'b1010011;
      4'd5:    s = 7'b1110110;
      4'd6:    s = 7'b1111110;
      4'd7:    s = 7'b0100011;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1110111;
      default: s = '0;
    endcase
    return s;
  endfunction

  // Level bars for a charge percent.
  function automatic logic [BARS_W-1:0] bars_of(input logic [PCT_W-1:0] pct);
    logic [BARS_W-1:0] b;
    if (pct >= 7'd90) begin
      b = Bars5;
    end else if (pct >= 7'd70) begin
      b = Bars4;
    end else if (pct >= 7'd50) begin
      b = Bars3;
    end else if (pct >= 7'd30) begin
      b = Bars2;
    end else if (pct >= 7'd5) begin
      b = Bars1;
    end else begin
      b = Bars0;
    end
    return b;
  endfunction

endpackage

[rtl/bmdd_encode.sv]
module bmdd_encode (
  input  logic signed [bmdd_pkg::MV_W-1:0]   voltage_mv_i,
  input  logic        [bmdd_pkg::STAT_W-1:0] status_i,
  output logic        [bmdd_pkg::WORD_W-1:0] word_o,
  output logic                               error_o
);

  logic [14:0]                      mv;
  logic [14:0]                      mv_off;
  logic [bmdd_pkg::PCT_W-1:0]       pct;
  logic [bmdd_pkg::BARS_W-1:0]      bars;
  logic [13:0]                      x;
  logic [29:0]                      prod10;
  logic [26:0]                      prod100;
  logic [27:0]                      prod1000;
  logic [9:0]                       r;
  logic [6:0]                       r_tens_all;
  logic [3:0]                       r_hund;
  logic [9:0]                       r_ones_full;
  logic [6:0]                       r_tens_full;
  logic [14:0]                      pprod;
  logic [3:0]                       p_tens;
  logic [6:0]                       p_ones_full;
  logic [3*bmdd_pkg::SEG_W-1:0]     volt_segs;
  logic [3*bmdd_pkg::SEG_W-1:0]     pct_segs;

  assign error_o = voltage_mv_i[bmdd_pkg::MV_W-1];
  assign mv      = voltage_mv_i[14:0];

  // Charge percent: one step per eight millivolts inside the window.
  assign mv_off = mv - bmdd_pkg::VoltLowMv;
  always_comb begin
    if (mv > bmdd_pkg::VoltHighMv) begin
      pct = 7'd100;
    end else if (mv < bmdd_pkg::VoltLowMv) begin
      pct = '0;
    end else begin
      pct = mv_off[9:3];
    end
  end
  assign bars = bmdd_pkg::bars_of(pct);

  // Voltage digits: x = mv + 5 stays below 10000 when not saturated, so the
  // reciprocal products below give exact quotients by 10, 100 and 1000.
  assign x        = mv[13:0] + 14'd5;
  assign prod10   = 30'(x) * 30'd52429;
  assign prod100  = 27'(x) * 27'd5243;
  assign prod1000 = 28'(x) * 28'd8389;
  assign r          = prod10[28:19];
  assign r_tens_all = prod100[25:19];
  assign r_hund     = prod1000[26:23];
  assign r_ones_full = r - 10'(r_tens_all) * 10'd10;
  assign r_tens_full = r_tens_all - 7'(r_hund) * 7'd10;

  always_comb begin
    if (mv > bmdd_pkg::VoltSatMv) begin
      volt_segs = {bmdd_pkg::seg_of(4'd9), bmdd_pkg::seg_of(4'd9),
                   bmdd_pkg::seg_of(4'd9)};
    end else begin
      volt_segs = {bmdd_pkg::seg_of(r_hund), bmdd_pkg::seg_of(r_tens_full[3:0]),
                   bmdd_pkg::seg_of(r_ones_full[3:0])};
    end
  end

  // Percent digits with leading blanks.
  assign pprod       = 15'(pct) * 15'd205;
  assign p_tens      = pprod[14:11];
  assign p_ones_full = pct - 7'(p_tens) * 7'd10;

  always_comb begin
    if (pct >= 7'd100) begin
      pct_segs = {bmdd_pkg::seg_of(4'd1), bmdd_pkg::seg_of(4'd0),
                  bmdd_pkg::seg_of(4'd0)};
    end else if (pct < 7'd10) begin
      pct_segs = {{(2*bmdd_pkg::SEG_W){1'b0}}, bmdd_pkg::seg_of(pct[3:0])};
    end else begin
      pct_segs = {{bmdd_pkg::SEG_W{1'b0}}, bmdd_pkg::seg_of(p_tens),
                  bmdd_pkg::seg_of(p_ones_full[3:0])};
    end
  end

  // Assemble the display word.
  always_comb begin
    if (status_i == '0) begin
      word_o = {bars, bmdd_pkg::IndVolt, volt_segs};
    end else begin
      word_o = {bars, bmdd_pkg::IndPct, pct_segs};
    end
  end

endmodule

[rtl/battery_meter_display_driver.sv]
// A sample accepted into the input register moves on to the result register,
// where it is offered as a result (input register, then result register).
// One sample per cycle unless out_stall_i holds the result register; the
// encoder is a single combinational pass. Reset (rst_ni low, asynchronous)
// empties both registers and clears the held display word to zero.
module battery_meter_display_driver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [bmdd_pkg::MV_W-1:0]   voltage_mv_i,
  input  logic        [bmdd_pkg::STAT_W-1:0] status_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic        [bmdd_pkg::WORD_W-1:0] display_word_o,
  output logic                               sensor_error_o
);

  logic                               s1_valid_q;
  logic signed [bmdd_pkg::MV_W-1:0]   s1_mv_q;
  logic        [bmdd_pkg::STAT_W-1:0] s1_status_q;
  logic                               s2_valid_q;
  logic        [bmdd_pkg::WORD_W-1:0] s2_word_q;
  logic                               s2_error_q;
  logic        [bmdd_pkg::WORD_W-1:0] held_q;
  logic        [bmdd_pkg::WORD_W-1:0] held_d;
  logic        [bmdd_pkg::WORD_W-1:0] enc_word;
  logic                               enc_error;
  logic                               s2_free;
  logic                               s1_move;
  logic                               in_take;

  // Handshake: the result register frees when empty or taken downstream.
  assign s2_free    = !s2_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;
  assign in_take    = in_valid_i && !in_stall_o;

  bmdd_encode u_encode (
    .voltage_mv_i (s1_mv_q),
    .status_i     (s1_status_q),
    .word_o       (enc_word),
    .error_o      (enc_error)
  );

  // A sensor error repeats the held word; otherwise the new word is held.
  assign held_d = enc_error ? held_q : enc_word;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_mv_q     <= voltage_mv_i;
      s1_status_q <= status_i;
    end
  end

  // Result register control and held display word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      held_q     <= '0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        held_q <= held_d;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_word_q  <= held_d;
      s2_error_q <= enc_error;
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign display_word_o = s2_word_q;
  assign sensor_error_o = s2_error_q;

`ifndef SYNTH
  // The word on offer always equals the held display word.
  a_word_is_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> display_word_o == held_q)
    else $error("offered display word differs from held word");

  // The held word changes only when a transaction enters the result register.
  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_move |=> $stable(held_q))
    else $error("held word changed without a transaction");

  // A good sample shows one of the two mode indicators.
  a_indicator: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sensor_error_o) |->
      (display_word_o[23:21] == bmdd_pkg::IndVolt ||
       display_word_o[23:21] == bmdd_pkg::IndPct))
    else $error("bad mode indicator");

  // A stalled sample stays in the input register unchanged.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_free) |=>
      (s1_valid_q && $stable(s1_mv_q) && $stable(s1_status_q)))
    else $error("input register lost a stalled sample");
`endif

endmodule
